>>> hdl/saf_pkg.sv
// Shared types and constants for the sample average filter.
// Used by saf_ctrl, saf_dpath and sample_average_filter_core; no dependencies.
`default_nettype none

package saf_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int POS_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WIN_W      = 5;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 8;
   localparam int NUM_COEF   = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int CSUM_W     = COEF_W + $clog2(WINDOW_MAX + 1);
   localparam int ACC_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int DIV_CNT_W  = $clog2(ACC_W);

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHTED_MODE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_LOW      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_HIGH     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_LEVEL   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_LEVEL    = 4'd5;

   localparam logic [ACC_W-1:0] START_LEVEL_RESET = 32'h4000_0000;
   localparam logic [ACC_W-1:0] STOP_LEVEL_RESET  = 32'h8000_0000;

   typedef struct packed {
      logic load_sample;
      logic cum_adjust;
      logic cum_add;
      logic plain_update;
      logic ring_write;
      logic mac_step;
      logic mac_drain;
      logic div_init;
      logic div_step;
      logic out_load;
   } saf_cmd_type;

   typedef struct packed {
      logic window_zero;
      logic weighted;
      logic mac_last;
      logic div_last;
      logic div_zero;
   } saf_status_type;

endpackage

`default_nettype wire

>>> hdl/saf_ctrl.sv
// Sequencer for the sample average filter: steps one item through update
// (weighted pass in weighted mode) and serial divide. Depends on saf_pkg.
`default_nettype none

module saf_ctrl
   import saf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire saf_status_type status,
   output saf_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUM_ADJUST,
      ST_CUM_ADD,
      ST_PLAIN,
      ST_RING,
      ST_MAC,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               if (status.window_zero) begin
                  state_in = ST_CUM_ADJUST;
               end else if (status.weighted) begin
                  state_in = ST_RING;
               end else begin
                  state_in = ST_PLAIN;
               end
            end
         end
         ST_CUM_ADJUST: begin
            cmd.cum_adjust = 1'b1;
            state_in       = ST_CUM_ADD;
         end
         ST_CUM_ADD: begin
            cmd.cum_add = 1'b1;
            state_in    = ST_DIV_INIT;
         end
         ST_PLAIN: begin
            cmd.plain_update = 1'b1;
            state_in         = ST_DIV_INIT;
         end
         ST_RING: begin
            cmd.ring_write = 1'b1;
            state_in       = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            if (status.mac_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.mac_drain = 1'b1;
            state_in      = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            // zero divisor needs no divide pass
            state_in = status.div_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/saf_dpath.sv
// Datapath of the sample average filter: configuration registers, sums,
// history ring, multiply-accumulate and restoring divider. Depends on saf_pkg.
`default_nettype none

module saf_dpath
   import saf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire saf_cmd_type           cmd,
   output saf_status_type             status,
   output logic [SAMPLE_W-1:0]        rsp_average,
   output logic                       rsp_divide_error
);

   // configuration
   logic [WIN_W-1:0]        window_ff;
   logic                    weighted_ff;
   logic [CSR_DATA_W-1:0]   coef_low_ff, coef_high_ff;
   logic [ACC_W-1:0]        start_level_ff, stop_level_ff;

   // filter state
   logic [ACC_W-1:0]        sum_ff, sum_in;
   logic [ACC_W-1:0]        count_ff, count_in;
   logic [ACC_W-1:0]        snap_sum_ff, snap_sum_in;
   logic [ACC_W-1:0]        snap_count_ff, snap_count_in;
   logic [POS_W-1:0]        oldest_ff, oldest_in;
   logic [SAMPLE_W-1:0]     ring_ff [WINDOW_MAX];

   // working registers
   logic [SAMPLE_W-1:0]     sample_ff;
   logic [POS_W-1:0]        idx_ff;
   logic [POS_W-1:0]        k_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic                    prod_valid_ff;
   logic [CSUM_W-1:0]       csum_ff;
   logic [ACC_W-1:0]        rem_ff;
   logic [ACC_W-1:0]        quo_ff;
   logic [ACC_W-1:0]        divisor_ff;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic                    div_zero_ff;
   logic [SAMPLE_W-1:0]     average_ff;
   logic                    error_ff;

   logic                    reinit;
   logic [WIN_W-1:0]        win;
   logic [POS_W-1:0]        pos;
   logic [POS_W-1:0]        pos_next;
   logic [POS_W-1:0]        idx_next;
   logic [POS_W-1:0]        rd_addr;
   logic [SAMPLE_W-1:0]     rd_data;
   logic [2*CSR_DATA_W-1:0] coef_all;
   logic [COEF_W-1:0]       coef_k;
   logic [ACC_W-1:0]        divisor_sel;
   logic [ACC_W:0]          rem_shift;
   logic [ACC_W:0]          rem_diff;

   assign reinit = csr_we && (csr_index <= REG_STOP_LEVEL);
   assign win    = (window_ff > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : window_ff;

   // ring positions wrap at the effective window
   always_comb begin
      pos = ({1'b0, oldest_ff} >= win) ? '0 : oldest_ff;
      if (WIN_W'(pos) + WIN_W'(1) >= win) begin
         pos_next = '0;
      end else begin
         pos_next = pos + POS_W'(1);
      end
      if (WIN_W'(idx_ff) + WIN_W'(1) >= win) begin
         idx_next = '0;
      end else begin
         idx_next = idx_ff + POS_W'(1);
      end
   end

   assign rd_addr  = cmd.mac_step ? idx_ff : pos;
   assign rd_data  = ring_ff[rd_addr];
   assign coef_all = {coef_high_ff, coef_low_ff};
   assign coef_k   = coef_all[{k_ff, 3'b000} +: COEF_W];

   // weighting applies only with a nonzero window
   assign divisor_sel = (weighted_ff && (win != '0)) ? ACC_W'(csum_ff) : count_ff;

   assign rem_shift = {rem_ff, quo_ff[ACC_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   assign status.window_zero = (win == '0);
   assign status.weighted    = weighted_ff;
   assign status.mac_last    = (WIN_W'(k_ff) == win - WIN_W'(1));
   assign status.div_last    = (div_cnt_ff == DIV_CNT_W'(ACC_W - 1));
   assign status.div_zero    = (divisor_sel == '0);

   assign rsp_average      = average_ff;
   assign rsp_divide_error = error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         weighted_ff    <= 1'b0;
         coef_low_ff    <= '0;
         coef_high_ff   <= '0;
         start_level_ff <= START_LEVEL_RESET;
         stop_level_ff  <= STOP_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: window_ff      <= csr_wdata[WIN_W-1:0];
            REG_WEIGHTED_MODE: weighted_ff    <= csr_wdata[0];
            REG_COEF_LOW:      coef_low_ff    <= csr_wdata;
            REG_COEF_HIGH:     coef_high_ff   <= csr_wdata;
            REG_START_LEVEL:   start_level_ff <= csr_wdata[ACC_W-1:0];
            REG_STOP_LEVEL:    stop_level_ff  <= csr_wdata[ACC_W-1:0];
            default: ;
         endcase
      end
   end

   // next values of the filter state
   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      snap_sum_in   = snap_sum_ff;
      snap_count_in = snap_count_ff;
      oldest_in     = oldest_ff;
      if (cmd.cum_adjust) begin
         // snapshot test first; subtract only when no snapshot is taken
         priority if (sum_ff >= start_level_ff && snap_sum_ff == '0) begin
            snap_sum_in   = sum_ff;
            snap_count_in = count_ff;
         end else if (sum_ff >= stop_level_ff) begin
            sum_in        = sum_ff - snap_sum_ff;
            count_in      = count_ff - snap_count_ff;
            snap_sum_in   = '0;
            snap_count_in = '0;
         end else begin
         end
      end
      if (cmd.cum_add) begin
         sum_in   = sum_ff + ACC_W'(sample_ff);
         count_in = count_ff + ACC_W'(1);
      end
      if (cmd.plain_update) begin
         sum_in    = sum_ff + ACC_W'(sample_ff) - ACC_W'(rd_data);
         oldest_in = pos_next;
         if (count_ff < ACC_W'(win)) begin
            count_in = count_ff + ACC_W'(1);
         end
      end
      if (cmd.ring_write) begin
         sum_in    = '0;
         oldest_in = pos_next;
      end
      if (cmd.mac_step && prod_valid_ff) begin
         sum_in = sum_ff + ACC_W'(prod_ff);
      end
      if (cmd.mac_drain) begin
         sum_in = sum_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || reinit) begin
         sum_ff        <= '0;
         count_ff      <= '0;
         snap_sum_ff   <= '0;
         snap_count_ff <= '0;
         oldest_ff     <= '0;
         for (int i = 0; i < WINDOW_MAX; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         snap_sum_ff   <= snap_sum_in;
         snap_count_ff <= snap_count_in;
         oldest_ff     <= oldest_in;
         if (cmd.plain_update || cmd.ring_write) begin
            ring_ff[pos] <= sample_ff;
         end
      end
   end

   // item latch, weighted pass and divider
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.ring_write) begin
         idx_ff        <= pos_next;
         k_ff          <= '0;
         csum_ff       <= '0;
         prod_valid_ff <= 1'b0;
      end
      if (cmd.mac_step) begin
         prod_ff       <= rd_data * coef_k;
         prod_valid_ff <= 1'b1;
         csum_ff       <= csum_ff + CSUM_W'(coef_k);
         k_ff          <= k_ff + POS_W'(1);
         idx_ff        <= idx_next;
      end
      if (cmd.div_init) begin
         divisor_ff  <= divisor_sel;
         quo_ff      <= sum_ff;
         rem_ff      <= '0;
         div_cnt_ff  <= '0;
         div_zero_ff <= (divisor_sel == '0);
      end
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         if (!rem_diff[ACC_W]) begin
            rem_ff <= rem_diff[ACC_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[ACC_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         average_ff <= div_zero_ff ? '0 : quo_ff[SAMPLE_W-1:0];
         error_ff   <= div_zero_ff;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sample_average_filter_core.sv
// Top level of the sample average filter: joins the sequencer and datapath.
// Depends on saf_pkg, saf_ctrl and saf_dpath.
//
//   port group | direction | contents
//   req_       | in        | sample (16 bits), valid/ready
//   rsp_       | out       | average (16 bits), divide_error, valid/ready
//   csr_       | in        | we, index (4 bits), wdata (64 bits)
//
// An item is accepted and then updated: cumulative mode adjusts and adds,
// plain mode updates sum and ring, weighted mode writes the ring and does one
// multiply per window entry. Then come divide setup, the bit-serial restoring
// divider (skipped on a zero divisor) and the load of the output register.
// Reset and any write to a known register clear sums, snapshots and the ring.
// A pending result in the output register does not block the next accept.
`default_nettype none

module sample_average_filter_core
   import saf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]        rsp_average,
   output logic                       rsp_divide_error,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   saf_cmd_type    cmd;
   saf_status_type status;

   saf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   saf_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_average      (rsp_average),
      .rsp_divide_error (rsp_divide_error)
   );

endmodule

`default_nettype wire
